@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Each macro takes a label, a clock, an active-low reset and the expressions to check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk_s, rstn_s, expr) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (expr)) \
		else $error("assertion failed");

// Check a consequent in the same cycle as its antecedent.
`define ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check a consequent in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/lsp_pkg.sv @@
// Shared types, codes and count helpers for the lead-screw position sequencer.
// No dependencies.
`timescale 1ns / 1ps

package lsp_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int CFG_WIDTH   = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int MODE_WIDTH  = 2;
	localparam int POS_WIDTH   = 2;
	localparam int WIDE_W      = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	// Event kinds carried by the mode field.
	localparam logic [MODE_WIDTH-1:0] MODE_STEP_TICK = 2'd0;
	localparam logic [MODE_WIDTH-1:0] MODE_MS_TICK   = 2'd1;
	localparam logic [MODE_WIDTH-1:0] MODE_TEST_KEY  = 2'd2;
	localparam logic [MODE_WIDTH-1:0] MODE_UNLD_KEY  = 2'd3;

	// Reported positions.
	localparam logic [POS_WIDTH-1:0] POS_NONE   = 2'd0;
	localparam logic [POS_WIDTH-1:0] POS_ZERO   = 2'd1;
	localparam logic [POS_WIDTH-1:0] POS_TEST   = 2'd2;
	localparam logic [POS_WIDTH-1:0] POS_UNLOAD = 2'd3;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_Z2T   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Z2U   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_T2U   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DWELL = 2'd3;

	localparam logic [CFG_WIDTH-1:0] RST_Z2T   = 16'd5039;
	localparam logic [CFG_WIDTH-1:0] RST_Z2U   = 16'd8188;
	localparam logic [CFG_WIDTH-1:0] RST_T2U   = 16'd13228;
	localparam logic [CFG_WIDTH-1:0] RST_DWELL = 16'd1000;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] z2t;
		logic [CFG_WIDTH-1:0] z2u;
		logic [CFG_WIDTH-1:0] t2u;
		logic [CFG_WIDTH-1:0] dwell;
	} cfg_t;

	typedef struct packed {
		logic                 step_pulse;
		logic                 direction;
		logic                 running;
		logic [POS_WIDTH-1:0] position;
		logic                 homed;
	} result_t;

	// Limit a register value to the counter range.
	function automatic count_t clamp_count(input logic [CFG_WIDTH-1:0] v);
		logic [WIDE_W-1:0] w;
		w = WIDE_W'(v);
		if (w > WIDE_W'(COUNT_MAX)) begin
			return COUNT_MAX;
		end
		return w[COUNT_WIDTH-1:0];
	endfunction

	// Saturating increment.
	function automatic count_t bump(input count_t v);
		if (v == COUNT_MAX) begin
			return v;
		end
		return v + 1'b1;
	endfunction

endpackage

@@ hw/rtl/lsp_cfg_regs.sv @@
// Configuration register file: step counts and dwell time.
// Depends on lsp_pkg.
`timescale 1ns / 1ps

module lsp_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [lsp_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [lsp_pkg::CFG_WIDTH-1:0]  wr_data,
	output lsp_pkg::cfg_t                  cfg
);
	import lsp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.z2t   <= RST_Z2T;
			cfg_q.z2u   <= RST_Z2U;
			cfg_q.t2u   <= RST_T2U;
			cfg_q.dwell <= RST_DWELL;
		end else if (wr_en) begin
			case (wr_index)
				REG_Z2T:   cfg_q.z2t   <= wr_data;
				REG_Z2U:   cfg_q.z2u   <= wr_data;
				REG_T2U:   cfg_q.t2u   <= wr_data;
				REG_DWELL: cfg_q.dwell <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/lsp_core.sv @@
// Positioning state machine: homing, counted moves, dwell and return.
// Depends on lsp_pkg.
`timescale 1ns / 1ps

module lsp_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  logic [lsp_pkg::MODE_WIDTH-1:0] mode,
	input  logic                           lim,
	input  lsp_pkg::cfg_t                  cfg,
	output lsp_pkg::result_t               res
);
	import lsp_pkg::*;

	typedef enum logic [2:0] {
		PH_START, PH_HOMING, PH_AT_ZERO, PH_TO_TEST,
		PH_TO_UNLOAD, PH_AT_TEST, PH_DWELL, PH_RETURN
	} phase_t;

	phase_t               phase_q, phase_d;
	count_t               cnt_q, cnt_d;
	count_t               tgt_q, tgt_d;
	count_t               dwell_q, dwell_d;
	count_t               dwell_lim;
	count_t               dwell_nx;
	logic                 lref_q, lref_d;
	logic                 dir_q, dir_d;
	logic                 found_q, found_d;
	logic [POS_WIDTH-1:0] org_q, org_d;
	logic                 pulse;

	assign dwell_lim = clamp_count(cfg.dwell);

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		tgt_d    = tgt_q;
		dwell_d  = dwell_q;
		lref_d   = lref_q;
		dir_d    = dir_q;
		found_d  = found_q;
		org_d    = org_q;
		pulse    = 1'b0;
		dwell_nx = dwell_q;

		case (phase_q)
			PH_START: begin
				lref_d  = lim;
				dir_d   = ~lim;
				cnt_d   = '0;
				phase_d = PH_HOMING;
			end
			PH_HOMING, PH_RETURN: begin
				if (lim != lref_q) begin
					phase_d = PH_AT_ZERO;
					cnt_d   = '0;
					found_d = 1'b1;
				end else if (mode == MODE_STEP_TICK) begin
					pulse = 1'b1;
					cnt_d = bump(cnt_q);
				end
			end
			PH_AT_ZERO: begin
				if (mode == MODE_TEST_KEY) begin
					phase_d = PH_TO_TEST;
					tgt_d   = clamp_count(cfg.z2t);
					cnt_d   = '0;
					dir_d   = 1'b1;
					org_d   = POS_ZERO;
				end else if (mode == MODE_UNLD_KEY) begin
					phase_d = PH_TO_UNLOAD;
					tgt_d   = clamp_count(cfg.z2u);
					cnt_d   = '0;
					dir_d   = 1'b0;
					org_d   = POS_ZERO;
				end
			end
			PH_AT_TEST: begin
				if (mode == MODE_UNLD_KEY) begin
					phase_d = PH_TO_UNLOAD;
					tgt_d   = clamp_count(cfg.t2u);
					cnt_d   = '0;
					dir_d   = 1'b0;
					org_d   = POS_TEST;
				end
			end
			PH_DWELL: begin
				if (mode == MODE_TEST_KEY) begin
					phase_d = PH_TO_TEST;
					tgt_d   = clamp_count(cfg.t2u);
					cnt_d   = '0;
					dir_d   = 1'b1;
					org_d   = POS_UNLOAD;
				end else begin
					if (mode == MODE_MS_TICK) begin
						dwell_nx = bump(dwell_q);
					end
					dwell_d = dwell_nx;
					if (dwell_nx >= dwell_lim) begin
						phase_d = PH_RETURN;
						dir_d   = 1'b1;
						cnt_d   = '0;
					end
				end
			end
			PH_TO_TEST, PH_TO_UNLOAD: begin
				if (mode == MODE_STEP_TICK && cnt_q < tgt_q) begin
					pulse = 1'b1;
					cnt_d = bump(cnt_q);
				end
			end
			default: ;
		endcase

		// Arrival check runs after any step, so a zero target lands on the press.
		if ((phase_d == PH_TO_TEST || phase_d == PH_TO_UNLOAD) && cnt_d >= tgt_d) begin
			cnt_d  = '0;
			lref_d = lim;
			if (phase_d == PH_TO_TEST) begin
				phase_d = PH_AT_TEST;
			end else begin
				dwell_d = '0;
				if (dwell_lim == '0) begin
					phase_d = PH_RETURN;
					dir_d   = 1'b1;
				end else begin
					phase_d = PH_DWELL;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			cnt_q   <= '0;
			tgt_q   <= '0;
			dwell_q <= '0;
			lref_q  <= 1'b0;
			dir_q   <= 1'b1;
			found_q <= 1'b0;
			org_q   <= POS_NONE;
		end else if (fire) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			tgt_q   <= tgt_d;
			dwell_q <= dwell_d;
			lref_q  <= lref_d;
			dir_q   <= dir_d;
			found_q <= found_d;
			org_q   <= org_d;
		end
	end

	always_comb begin
		res.step_pulse = pulse;
		res.direction  = dir_d;
		res.homed      = found_d;
		res.running    = (phase_d == PH_HOMING || phase_d == PH_TO_TEST ||
		                  phase_d == PH_TO_UNLOAD || phase_d == PH_RETURN);
		case (phase_d)
			PH_AT_ZERO:              res.position = POS_ZERO;
			PH_AT_TEST:              res.position = POS_TEST;
			PH_DWELL, PH_RETURN:     res.position = POS_UNLOAD;
			PH_TO_TEST, PH_TO_UNLOAD: res.position = org_d;
			default:                 res.position = POS_NONE;
		endcase
	end

endmodule

@@ hw/rtl/leadscrew_position_sequencer.sv @@
// Top level of the lead-screw position sequencer: input register, core, result register.
// Depends on lsp_pkg, lsp_cfg_regs and lsp_core.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    mode, limit_level
//   out      out_valid/out_ready  step_pulse, direction, running, position, homed
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One event word is taken per cycle while the result side does not stall; its result word
// passes the input register, then the result register, before it is offered.
// The core's next-state logic sits between those two registers and updates once per word.
// Reset clears the state machine to its pre-homing state and loads register defaults.
// A stalled result holds the result register; the input register still takes a word
// while the result is being taken in the same cycle. cfg_ready is always high.
`timescale 1ns / 1ps

module leadscrew_position_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [lsp_pkg::MODE_WIDTH-1:0] mode,
	input  logic                           limit_level,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           step_pulse,
	output logic                           direction,
	output logic                           running,
	output logic [lsp_pkg::POS_WIDTH-1:0]  position,
	output logic                           homed,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsp_pkg::CFG_WIDTH-1:0]  cfg_data
);
	import lsp_pkg::*;

	cfg_t                  cfg;
	result_t               res;
	result_t               res_s2;
	logic                  valid_s1;
	logic [MODE_WIDTH-1:0] mode_s1;
	logic                  lim_s1;
	logic                  valid_s2;
	logic                  advance;

	// Advance the held word into the result register when that register is free
	// or being emptied this cycle.
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	lsp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	lsp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.mode   (mode_s1),
		.lim    (lim_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Input register: capture an accepted word, drop the valid once it advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			lim_s1  <= limit_level;
		end
	end

	// Result register: load on advance, hold while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid  = valid_s2;
	assign step_pulse = res_s2.step_pulse;
	assign direction  = res_s2.direction;
	assign running    = res_s2.running;
	assign position   = res_s2.position;
	assign homed      = res_s2.homed;

endmodule

@@ hw/rtl/lsp_checker.sv @@
// Port-level checker for the lead-screw position sequencer, bound to the top level.
// Depends on lsp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lsp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          step_pulse,
	input logic                          direction,
	input logic                          running,
	input logic [lsp_pkg::POS_WIDTH-1:0] position,
	input logic                          homed
);
	import lsp_pkg::*;

	logic       stalled;
	logic [5:0] status;

	assign stalled = out_valid && !out_ready;
	assign status  = {step_pulse, direction, running, position, homed};

	`ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, out_valid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, stalled, $stable(status))
	`ASSERT_SAME(a_unhomed_pos, clk, arst_n, out_valid && !homed, position == POS_NONE)
	`ASSERT_ALWAYS(a_test_move_dir, clk, arst_n, !(out_valid && running && position == POS_TEST && direction))

endmodule

bind leadscrew_position_sequencer lsp_checker u_lsp_checker (.*);

@@ test/tb_top.sv @@
// Self-checking bench for leadscrew_position_sequencer: table-driven directed words,
// then state-aware random words and a full-range dwell, checked by a predictor or a row's status.
// Depends on lsp_pkg and the RTL of leadscrew_position_sequencer.
`timescale 1ns / 1ps

module tb_top;
	import lsp_pkg::*;

	typedef enum logic [2:0] {
		ST_START, ST_HOMING, ST_AT_ZERO, ST_TO_TEST,
		ST_TO_UNLOAD, ST_AT_TEST, ST_DWELL, ST_RETURN
	} seq_state_t;

	// One table row: either load all four registers, or send one event word.
	typedef struct packed {
		logic                  load;
		cfg_t                  regs;
		logic [MODE_WIDTH-1:0] ev;
		logic                  lim;
		logic                  typed;
		result_t               want;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [MODE_WIDTH-1:0] mode;
	logic                  limit_level;
	logic                  out_valid;
	logic                  out_ready;
	logic                  step_pulse;
	logic                  direction;
	logic                  running;
	logic [POS_WIDTH-1:0]  position;
	logic                  homed;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_WIDTH-1:0]  cfg_data;

	// Predictor state, reset values.
	seq_state_t           st          = ST_START;
	count_t               steps_done  = '0;
	count_t               steps_goal  = '0;
	logic                 ref_lim     = 1'b0;
	count_t               dwell_ticks = '0;
	logic                 dir_bit     = 1'b1;
	logic                 zero_seen   = 1'b0;
	logic [POS_WIDTH-1:0] move_from   = POS_NONE;
	cfg_t                 cfg_now     = '{RST_Z2T, RST_Z2U, RST_T2U, RST_DWELL};

	result_t pending_status[$];
	bit      gaps_on = 1'b1;
	logic    sw_level = 1'b0;
	int      mismatches = 0;
	int      words_sent = 0;
	int      words_checked = 0;
	int      settings_loaded = 0;

	localparam int N_ROWS = 23;
	localparam row_t ROWS [N_ROWS] = '{
		// homing under reset registers
		'{1'b0, '0, MODE_UNLD_KEY,  1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, POS_NONE, 1'b0}},
		'{1'b0, '0, MODE_STEP_TICK, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b1, POS_NONE, 1'b0}},
		'{1'b0, '0, MODE_TEST_KEY,  1'b1, 1'b0, '0},
		'{1'b0, '0, MODE_MS_TICK,   1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, POS_ZERO, 1'b1}},
		// zero-length move to test, one-step move to unload, no dwell
		'{1'b1, '{16'd0, 16'd2, 16'd1, 16'd0}, MODE_STEP_TICK, 1'b0, 1'b0, '0},
		'{1'b0, '0, MODE_TEST_KEY,  1'b0, 1'b1, '{1'b0, 1'b1, 1'b0, POS_TEST, 1'b1}},
		'{1'b0, '0, MODE_TEST_KEY,  1'b0, 1'b0, '0},
		'{1'b0, '0, MODE_UNLD_KEY,  1'b1, 1'b0, '0},
		'{1'b0, '0, MODE_TEST_KEY,  1'b1, 1'b0, '0},
		'{1'b0, '0, MODE_STEP_TICK, 1'b1, 1'b0, '0},
		'{1'b0, '0, MODE_STEP_TICK, 1'b1, 1'b0, '0},
		'{1'b0, '0, MODE_UNLD_KEY,  1'b1, 1'b0, '0},
		'{1'b0, '0, MODE_MS_TICK,   1'b0, 1'b0, '0},
		// zero-length move to unload, dwell cancelled by a test press
		'{1'b1, '{16'd1, 16'd0, 16'd3, 16'd2}, MODE_STEP_TICK, 1'b0, 1'b0, '0},
		'{1'b0, '0, MODE_UNLD_KEY,  1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, POS_UNLOAD, 1'b1}},
		'{1'b0, '0, MODE_MS_TICK,   1'b0, 1'b0, '0},
		'{1'b0, '0, MODE_TEST_KEY,  1'b0, 1'b0, '0},
		'{1'b0, '0, MODE_MS_TICK,   1'b1, 1'b0, '0},
		'{1'b0, '0, MODE_STEP_TICK, 1'b1, 1'b0, '0},
		'{1'b0, '0, MODE_STEP_TICK, 1'b0, 1'b0, '0},
		'{1'b0, '0, MODE_STEP_TICK, 1'b1, 1'b0, '0},
		'{1'b0, '0, MODE_STEP_TICK, 1'b1, 1'b0, '0},
		'{1'b0, '0, MODE_UNLD_KEY,  1'b1, 1'b0, '0}
	};

	leadscrew_position_sequencer DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.limit_level (limit_level),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.step_pulse  (step_pulse),
		.direction   (direction),
		.running     (running),
		.position    (position),
		.homed       (homed),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag(input string msg);
		mismatches++;
		$display("tb_top: mismatch at %0t: %s", $time, msg);
	endtask

	task automatic cmp_field(input string name, input logic [1:0] got, input logic [1:0] want);
		if (got !== want) begin
			flag($sformatf("%s got %0d, want %0d", name, got, want));
		end
	endtask

	function automatic count_t sat_inc(input count_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic void launch(input seq_state_t to, input count_t goal, input logic d,
			input logic [POS_WIDTH-1:0] from);
		st = to;
		steps_goal = goal;
		steps_done = '0;
		dir_bit = d;
		move_from = from;
	endfunction

	// Advance the predictor by one event word and return the status it produces.
	function automatic result_t predict_status(input logic [MODE_WIDTH-1:0] m, input logic l);
		result_t r;
		r = '0;
		case (st)
			ST_START: begin
				ref_lim = l;
				dir_bit = ~l;
				steps_done = '0;
				st = ST_HOMING;
			end
			ST_HOMING, ST_RETURN: begin
				if (l != ref_lim) begin
					st = ST_AT_ZERO;
					steps_done = '0;
					zero_seen = 1'b1;
				end else if (m == MODE_STEP_TICK) begin
					r.step_pulse = 1'b1;
					steps_done = sat_inc(steps_done);
				end
			end
			ST_AT_ZERO: begin
				if (m == MODE_TEST_KEY) begin
					launch(ST_TO_TEST, count_t'(cfg_now.z2t), 1'b1, POS_ZERO);
				end else if (m == MODE_UNLD_KEY) begin
					launch(ST_TO_UNLOAD, count_t'(cfg_now.z2u), 1'b0, POS_ZERO);
				end
			end
			ST_AT_TEST: begin
				if (m == MODE_UNLD_KEY) begin
					launch(ST_TO_UNLOAD, count_t'(cfg_now.t2u), 1'b0, POS_TEST);
				end
			end
			ST_DWELL: begin
				if (m == MODE_TEST_KEY) begin
					launch(ST_TO_TEST, count_t'(cfg_now.t2u), 1'b1, POS_UNLOAD);
				end else begin
					if (m == MODE_MS_TICK) begin
						dwell_ticks = sat_inc(dwell_ticks);
					end
					if (dwell_ticks >= count_t'(cfg_now.dwell)) begin
						st = ST_RETURN;
						dir_bit = 1'b1;
						steps_done = '0;
					end
				end
			end
			default: begin
				if (m == MODE_STEP_TICK && steps_done < steps_goal) begin
					r.step_pulse = 1'b1;
					steps_done = sat_inc(steps_done);
				end
			end
		endcase

		// Arrival is checked after any step, so a zero-length move lands on the press.
		if ((st == ST_TO_TEST || st == ST_TO_UNLOAD) && steps_done >= steps_goal) begin
			steps_done = '0;
			ref_lim = l;
			if (st == ST_TO_TEST) begin
				st = ST_AT_TEST;
			end else begin
				st = ST_DWELL;
				dwell_ticks = '0;
				if (dwell_ticks >= count_t'(cfg_now.dwell)) begin
					st = ST_RETURN;
					dir_bit = 1'b1;
				end
			end
		end

		r.direction = dir_bit;
		r.running = st inside {ST_HOMING, ST_TO_TEST, ST_TO_UNLOAD, ST_RETURN};
		case (st)
			ST_AT_ZERO:              r.position = POS_ZERO;
			ST_AT_TEST:              r.position = POS_TEST;
			ST_DWELL, ST_RETURN:     r.position = POS_UNLOAD;
			ST_TO_TEST, ST_TO_UNLOAD: r.position = move_from;
			default:                 r.position = POS_NONE;
		endcase
		r.homed = zero_seen;
		return r;
	endfunction

	// Send one event word; hold valid until it is taken, then queue its status.
	task automatic send_word(input logic [MODE_WIDTH-1:0] m, input logic l,
			input logic typed = 1'b0, input result_t want = '0);
		result_t r;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		limit_level <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = predict_status(m, l);
		pending_status.push_back(typed ? want : r);
		words_sent++;
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_WIDTH-1:0] v);
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic program_regs(input cfg_t v);
		cfg_valid <= 1'b1;
		put_reg(REG_Z2T, v.z2t);
		put_reg(REG_Z2U, v.z2u);
		put_reg(REG_T2U, v.t2u);
		put_reg(REG_DWELL, v.dwell);
		cfg_valid <= 1'b0;
		cfg_now = v;
		settings_loaded++;
	endtask

	// Drop valid, wait out every queued status and the pipeline behind it.
	task automatic settle();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (pending_status.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_status.size() != 0) begin
			flag($sformatf("%0d status words never arrived", pending_status.size()));
			pending_status.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	// Pick a word that mostly pushes the current move along, with some noise.
	task automatic roll_word(output logic [MODE_WIDTH-1:0] m, output logic l);
		int r;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0) begin
			sw_level = ~sw_level;
		end
		l = sw_level;
		m = MODE_WIDTH'($urandom_range(0, 3));
		if (r < 10) begin
			l = 1'($urandom_range(0, 1));
		end else begin
			case (st)
				ST_TO_TEST, ST_TO_UNLOAD: if (r < 80) m = MODE_STEP_TICK;
				ST_HOMING, ST_RETURN:     if (r < 70) m = MODE_STEP_TICK;
				ST_DWELL: begin
					if (r < 70) m = MODE_MS_TICK;
					else if (r < 80) m = MODE_TEST_KEY;
				end
				default: ;
			endcase
		end
	endtask

	// Result side: random stall bursts, compare every taken word with the oldest prediction.
	initial begin
		result_t want;
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				words_checked++;
				if (pending_status.size() == 0) begin
					flag("status word with nothing pending");
				end else begin
					want = pending_status.pop_front();
					cmp_field("step_pulse", 2'(step_pulse), 2'(want.step_pulse));
					cmp_field("direction", 2'(direction), 2'(want.direction));
					cmp_field("running", 2'(running), 2'(want.running));
					cmp_field("position", position, want.position);
					cmp_field("homed", 2'(homed), 2'(want.homed));
				end
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 2);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		cfg_t pick;
		logic [MODE_WIDTH-1:0] m;
		logic l;
		int lo;
		int hi;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_STEP_TICK;
		limit_level <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_Z2T;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		for (int i = 0; i < N_ROWS; i++) begin
			if (ROWS[i].load) begin
				settle();
				program_regs(ROWS[i].regs);
			end else begin
				send_word(ROWS[i].ev, ROWS[i].lim, ROWS[i].typed, ROWS[i].want);
			end
		end

		// Random phases, each under a fresh register setting.
		for (int ph = 0; ph < 6; ph++) begin
			settle();
			lo = 0;
			hi = 15;
			if (ph == 1) hi = 0;
			if (ph == 3) begin
				lo = 20;
				hi = 200;
			end
			pick.z2t = CFG_WIDTH'($urandom_range(lo, hi));
			pick.z2u = CFG_WIDTH'($urandom_range(lo, hi));
			pick.t2u = CFG_WIDTH'($urandom_range(lo, hi));
			pick.dwell = CFG_WIDTH'($urandom_range(lo, hi));
			program_regs(pick);
			gaps_on = (ph != 4);
			repeat (255) begin
				roll_word(m, l);
				send_word(m, l);
			end
		end

		// Walk back to zero under the last small setting.
		while (st != ST_AT_ZERO) begin
			m = MODE_STEP_TICK;
			l = sw_level;
			case (st)
				ST_HOMING, ST_RETURN: l = ~ref_lim;
				ST_DWELL:             m = MODE_MS_TICK;
				ST_AT_TEST:           m = MODE_UNLD_KEY;
				default: ;
			endcase
			send_word(m, l);
		end
		settle();

		// Full-range dwell: land on unload at once, then cancel the longest dwell twice.
		gaps_on = 1'b0;
		program_regs('{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF});
		send_word(MODE_UNLD_KEY, sw_level);
		repeat (3) send_word(MODE_MS_TICK, ~sw_level);
		send_word(MODE_TEST_KEY, sw_level);
		send_word(MODE_UNLD_KEY, ~sw_level);
		send_word(MODE_MS_TICK, sw_level);
		send_word(MODE_TEST_KEY, sw_level);
		settle();

		$display("tb_top: %0d event words sent, %0d status words checked, %0d mismatches",
			words_sent, words_checked, mismatches);
		$display("tb_top: homing, counted moves, dwell and return under %0d register settings",
			settings_loaded);
		if (mismatches == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
